FILE: design/rgbcli_pkg.sv
`default_nettype none

package rgbcli_pkg;

   // special bytes
   localparam logic [7:0] CHAR_ENTER     = 8'd13;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd127;
   localparam logic [7:0] CHAR_PLUS      = 8'd43;
   localparam logic [7:0] CHAR_ZERO      = 8'd48;
   localparam logic [7:0] CHAR_NINE      = 8'd57;
   localparam logic [7:0] CHAR_R         = 8'd114;
   localparam logic [7:0] CHAR_G         = 8'd103;
   localparam logic [7:0] CHAR_B         = 8'd98;

   // saturation point of the digit accumulator
   localparam logic [9:0] ACC_CAP = 10'd1000;

   // reset value of the level limit register
   localparam logic [7:0] LIMIT_RESET = 8'd255;

   // word queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // kind of received word, decided in the front
   typedef enum logic [1:0] {
      KIND_CHAR,
      KIND_BACK,
      KIND_ENTER
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } queue_entry_type;

   // result codes
   typedef enum logic [2:0] {
      OUT_ECHO_CHAR  = 3'd0,
      OUT_ECHO_BACK  = 3'd1,
      OUT_LEVEL_SET  = 3'd2,
      OUT_INVALID    = 3'd3,
      OUT_NO_COMMAND = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      CH_RED   = 2'd0,
      CH_GREEN = 2'd1,
      CH_BLUE  = 2'd2
   } channel_type;

   // back sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_PARSE,
      BK_RESULT
   } back_state_type;

   // parser phases while walking the line
   typedef enum logic [2:0] {
      PH_FIRST,
      PH_KEYWORD,
      PH_SPACE,
      PH_SIGN,
      PH_DIGITS
   } phase_type;

   // keyword character k of a channel's name
   function automatic logic [7:0] kw_char(input channel_type ch, input logic [2:0] k);
      logic [7:0] c;
      c = 8'd0;
      case (ch)
         CH_RED: begin
            case (k)
               3'd0:    c = "r";
               3'd1:    c = "e";
               3'd2:    c = "d";
               default: c = 8'd0;
            endcase
         end
         CH_GREEN: begin
            case (k)
               3'd0:    c = "g";
               3'd1:    c = "r";
               3'd2:    c = "e";
               3'd3:    c = "e";
               3'd4:    c = "n";
               default: c = 8'd0;
            endcase
         end
         CH_BLUE: begin
            case (k)
               3'd0:    c = "b";
               3'd1:    c = "l";
               3'd2:    c = "u";
               3'd3:    c = "e";
               default: c = 8'd0;
            endcase
         end
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   // keyword length of a channel's name
   function automatic logic [2:0] kw_len(input channel_type ch);
      logic [2:0] n;
      case (ch)
         CH_RED:   n = 3'd3;
         CH_GREEN: n = 3'd5;
         CH_BLUE:  n = 3'd4;
         default:  n = 3'd3;
      endcase
      return n;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {[8'd9:8'd13], 8'd32});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {[CHAR_ZERO:CHAR_NINE]});
   endfunction

endpackage

`default_nettype wire

FILE: design/rgb_command_line_interpreter.sv
// RGB command line interpreter
//
// Bytes from a serial receiver enter on the req_ channel (valid/ready). Each
// accepted word gives at most one word on the rsp_ channel: an echo of an
// ordinary byte, an echo of a backspace, or on Enter the outcome of parsing
// the line ("red N", "green N", "blue N") with channel, level and duty.
// csr_wr_en/csr_wr_data write the level limit; write it only while idle.
//
// A two-word queue sits between the front, which classifies bytes, and the
// back, which edits the line memory and walks it on Enter.
// An echo is held in the queue entry and then in the output register. Enter
// reads the line memory one byte per cycle through a registered read; its
// result is then held in the output register. Throughput: one ordinary byte
// or backspace per cycle, while the receiver takes results and no line parses.
//
// Reset clears the queue, the line length, the output valid flag and sets the
// limit to 255. When the receiver stalls rsp_ready, the result holds in the
// output register, the back waits and the queue fills, then req_ready drops.
`default_nettype none

module rgb_command_line_interpreter
   import rgbcli_pkg::*;
#(
   parameter int LINE_DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_outcome,
   output logic [7:0]       rsp_echo_char,
   output logic [1:0]       rsp_channel,
   output logic [7:0]       rsp_level,
   output logic [15:0]      rsp_duty,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data
);

   logic            head_valid;
   queue_entry_type head;
   logic            head_pop;

   // front: accept and classify
   rgbcli_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   // back: line store, parser, output register
   rgbcli_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .head_pop      (head_pop),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_outcome   (rsp_outcome),
      .rsp_echo_char (rsp_echo_char),
      .rsp_channel   (rsp_channel),
      .rsp_level     (rsp_level),
      .rsp_duty      (rsp_duty)
   );

   // the back never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset) head_pop |-> head_valid)
      else $error("queue popped while empty");

   // duty is the square of the level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_LEVEL_SET) |->
         rsp_duty == 16'(rsp_level) * 16'(rsp_level))
      else $error("duty does not match level");

   // a backspace echo always carries the backspace code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome == OUT_ECHO_BACK) |-> rsp_echo_char == CHAR_BACKSPACE)
      else $error("backspace echo with wrong character");

   // channel is zero unless a command was recognised
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != OUT_LEVEL_SET && rsp_outcome != OUT_INVALID)
         |-> rsp_channel == 2'd0)
      else $error("channel set on a result without a command");

endmodule

`default_nettype wire

FILE: design/rgbcli_front.sv
`default_nettype none

module rgbcli_front
   import rgbcli_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [7:0]      req_rx_byte,
   output logic                 head_valid,
   output queue_entry_type      head,
   input  wire logic            head_pop
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   queue_entry_type   fifo_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   queue_entry_type   entry;
   logic              push;

   // classify the incoming word
   always_comb begin
      entry.data = req_rx_byte;
      case (req_rx_byte)
         CHAR_ENTER:     entry.kind = KIND_ENTER;
         CHAR_BACKSPACE: entry.kind = KIND_BACK;
         default:        entry.kind = KIND_CHAR;
      endcase
   end

   assign req_ready  = (count_ff != CNT_FULL);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = fifo_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/rgbcli_back.sv
`default_nettype none

module rgbcli_back
   import rgbcli_pkg::*;
#(
   parameter int LINE_DEPTH = 128
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  wire queue_entry_type head,
   output logic                 head_pop,
   input  wire logic            csr_wr_en,
   input  wire logic [7:0]      csr_wr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [2:0]           rsp_outcome,
   output logic [7:0]           rsp_echo_char,
   output logic [1:0]           rsp_channel,
   output logic [7:0]           rsp_level,
   output logic [15:0]          rsp_duty
);

   localparam int IDX_W = $clog2(LINE_DEPTH);
   localparam int LEN_W = $clog2(LINE_DEPTH + 1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH);

   // line store
   logic [7:0]        line_mem [LINE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [IDX_W-1:0]  mem_raddr;

   back_state_type    state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  pos_next;
   logic [2:0]        kidx_ff, kidx_in;
   logic [2:0]        kidx_next;
   channel_type       chan_ff, chan_in;
   logic [9:0]        acc_ff, acc_in;
   logic              found_ff, found_in;
   logic [7:0]        limit_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   outcome_type       rsp_outcome_ff, rsp_outcome_in;
   logic [7:0]        rsp_echo_char_ff, rsp_echo_char_in;
   logic [1:0]        rsp_channel_ff, rsp_channel_in;
   logic [7:0]        rsp_level_ff, rsp_level_in;
   logic [15:0]       rsp_duty_ff, rsp_duty_in;

   logic              out_free;
   logic [3:0]        digit;
   logic [13:0]       acc_x10;
   logic [9:0]        acc_sat;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pos_next  = pos_ff + 1'b1;
   assign kidx_next = kidx_ff + 3'd1;

   // decimal accumulate with saturation
   assign digit   = 4'(rd_data_ff - CHAR_ZERO);
   assign acc_x10 = 14'({acc_ff, 3'b000}) + 14'({acc_ff, 1'b0}) + 14'(digit);
   assign acc_sat = (acc_x10 > 14'(ACC_CAP)) ? ACC_CAP : acc_x10[9:0];

   // sequencer: edit the line, walk it on enter, emit at most one word
   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      length_in        = length_ff;
      pos_in           = pos_ff;
      kidx_in          = kidx_ff;
      chan_in          = chan_ff;
      acc_in           = acc_ff;
      found_in         = found_ff;
      head_pop         = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = length_ff[IDX_W-1:0];
      mem_raddr        = pos_next[IDX_W-1:0];
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_outcome_in   = rsp_outcome_ff;
      rsp_echo_char_in = rsp_echo_char_ff;
      rsp_channel_in   = rsp_channel_ff;
      rsp_level_in     = rsp_level_ff;
      rsp_duty_in      = rsp_duty_ff;

      case (state_ff)
         BK_IDLE: begin
            if (head_valid && out_free) begin
               head_pop = 1'b1;
               case (head.kind)
                  KIND_CHAR: begin
                     // dropped silently when the line is full
                     if (length_ff != LEN_MAX) begin
                        mem_we           = 1'b1;
                        length_in        = length_ff + 1'b1;
                        rsp_valid_in     = 1'b1;
                        rsp_outcome_in   = OUT_ECHO_CHAR;
                        rsp_echo_char_in = head.data;
                        rsp_channel_in   = 2'd0;
                        rsp_level_in     = 8'd0;
                        rsp_duty_in      = 16'd0;
                     end
                  end
                  KIND_BACK: begin
                     if (length_ff != '0) begin
                        length_in        = length_ff - 1'b1;
                        rsp_valid_in     = 1'b1;
                        rsp_outcome_in   = OUT_ECHO_BACK;
                        rsp_echo_char_in = CHAR_BACKSPACE;
                        rsp_channel_in   = 2'd0;
                        rsp_level_in     = 8'd0;
                        rsp_duty_in      = 16'd0;
                     end
                  end
                  KIND_ENTER: begin
                     mem_raddr = '0;
                     pos_in    = '0;
                     phase_in  = PH_FIRST;
                     kidx_in   = 3'd0;
                     acc_in    = 10'd0;
                     found_in  = 1'b0;
                     state_in  = BK_PARSE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         BK_PARSE: begin
            // rd_data_ff holds the byte at pos_ff
            pos_in = pos_next;
            if (pos_ff == length_ff) begin
               found_in = (phase_ff == PH_DIGITS);
               state_in = BK_RESULT;
            end else begin
               case (phase_ff)
                  PH_FIRST: begin
                     kidx_in  = 3'd1;
                     phase_in = PH_KEYWORD;
                     case (rd_data_ff)
                        CHAR_R: chan_in = CH_RED;
                        CHAR_G: chan_in = CH_GREEN;
                        CHAR_B: chan_in = CH_BLUE;
                        default: begin
                           found_in = 1'b0;
                           state_in = BK_RESULT;
                        end
                     endcase
                  end
                  PH_KEYWORD: begin
                     if (rd_data_ff == kw_char(chan_ff, kidx_ff)) begin
                        kidx_in = kidx_next;
                        if (kidx_next == kw_len(chan_ff)) begin
                           phase_in = PH_SPACE;
                        end
                     end else begin
                        found_in = 1'b0;
                        state_in = BK_RESULT;
                     end
                  end
                  PH_SPACE: begin
                     if (is_space(rd_data_ff)) begin
                        phase_in = PH_SPACE;
                     end else if (rd_data_ff == CHAR_PLUS) begin
                        phase_in = PH_SIGN;
                     end else if (is_digit(rd_data_ff)) begin
                        acc_in   = 10'(digit);
                        phase_in = PH_DIGITS;
                     end else begin
                        found_in = 1'b0;
                        state_in = BK_RESULT;
                     end
                  end
                  PH_SIGN: begin
                     if (is_digit(rd_data_ff)) begin
                        acc_in   = 10'(digit);
                        phase_in = PH_DIGITS;
                     end else begin
                        found_in = 1'b0;
                        state_in = BK_RESULT;
                     end
                  end
                  PH_DIGITS: begin
                     // trailing text after the digits is ignored
                     if (is_digit(rd_data_ff)) begin
                        acc_in = acc_sat;
                     end else begin
                        found_in = 1'b1;
                        state_in = BK_RESULT;
                     end
                  end
                  default: begin
                     found_in = 1'b0;
                     state_in = BK_RESULT;
                  end
               endcase
            end
         end

         BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_echo_char_in = 8'd0;
               rsp_channel_in   = 2'd0;
               rsp_level_in     = 8'd0;
               rsp_duty_in      = 16'd0;
               if (!found_ff) begin
                  rsp_outcome_in = OUT_NO_COMMAND;
               end else if (acc_ff > {2'b00, limit_ff}) begin
                  rsp_outcome_in = OUT_INVALID;
                  rsp_channel_in = chan_ff;
               end else begin
                  rsp_outcome_in = OUT_LEVEL_SET;
                  rsp_channel_in = chan_ff;
                  rsp_level_in   = acc_ff[7:0];
                  rsp_duty_in    = 16'(acc_ff[7:0]) * 16'(acc_ff[7:0]);
               end
               length_in = '0;
               state_in  = BK_IDLE;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // parser and result payload
   always_ff @(posedge clock) begin
      phase_ff         <= phase_in;
      pos_ff           <= pos_in;
      kidx_ff          <= kidx_in;
      chan_ff          <= chan_in;
      acc_ff           <= acc_in;
      found_ff         <= found_in;
      rsp_outcome_ff   <= rsp_outcome_in;
      rsp_echo_char_ff <= rsp_echo_char_in;
      rsp_channel_ff   <= rsp_channel_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_duty_ff      <= rsp_duty_in;
   end

   // line memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= head.data;
      end
      rd_data_ff <= line_mem[mem_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_echo_char = rsp_echo_char_ff;
   assign rsp_channel   = rsp_channel_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_duty      = rsp_duty_ff;

endmodule

`default_nettype wire

FILE: verif/tb_rgb_command_line_interpreter.sv
`default_nettype none

module tb_rgb_command_line_interpreter
   import rgbcli_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH  = 128;
   localparam int CYCLE_LIMIT = 2_000_000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [2:0]  rsp_outcome;
   logic [7:0]  rsp_echo_char;
   logic [1:0]  rsp_channel;
   logic [7:0]  rsp_level;
   logic [15:0] rsp_duty;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;

   bit idle_mode   = 1'b1;
   int stall_left  = 0;
   int bytes_sent  = 0;
   int cycle_count = 0;

   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  echo_char;
      channel_type channel;
      logic [7:0]  level;
      logic [15:0] duty;
   } console_reply_type;

   // keyword that selects a channel
   function automatic string channel_word(channel_type ch);
      case (ch)
         CH_RED:   return "red";
         CH_GREEN: return "green";
         default:  return "blue";
      endcase
   endfunction

   // line buffer, level limit and the replies still due from the block
   class console_scoreboard;
      logic [7:0]        line_bytes [LINE_DEPTH];
      int                line_fill;
      logic [7:0]        level_limit;
      console_reply_type replies_due [$];
      int                errors;

      function new();
         line_fill   = 0;
         level_limit = LIMIT_RESET;
         errors      = 0;
      endfunction

      // try one keyword on the first n bytes; value saturates at 1000
      function bit keyword_value(channel_type ch, int n, output int val);
         string kw;
         int    p;
         int    k;
         int    acc;
         bit    any;
         kw  = channel_word(ch);
         p   = 0;
         acc = 0;
         any = 1'b0;
         val = 0;
         for (k = 0; k < kw.len(); k++) begin
            if (p >= n || line_bytes[p] != kw[k]) return 1'b0;
            p++;
         end
         while (p < n && (line_bytes[p] == 8'd32 ||
                          (line_bytes[p] >= 8'd9 && line_bytes[p] <= 8'd13)))
            p++;
         if (p < n && line_bytes[p] == "+") p++;
         while (p < n && line_bytes[p] >= "0" && line_bytes[p] <= "9") begin
            acc = acc * 10 + int'(line_bytes[p] - "0");
            if (acc > 1000) acc = 1000;
            any = 1'b1;
            p++;
         end
         val = acc;
         return any;
      endfunction

      // work out the reply, if any, to one accepted byte
      function void predict_reply(logic [7:0] b);
         console_reply_type r;
         int                n;
         int                val;
         bit                hit;
         channel_type       ch;
         r   = '0;
         hit = 1'b0;
         ch  = CH_RED;
         if (b == CHAR_ENTER) begin
            n = 0;
            while (n < line_fill && line_bytes[n] != 8'd0) n++;
            if (keyword_value(CH_RED, n, val)) begin
               hit = 1'b1;
               ch  = CH_RED;
            end else if (keyword_value(CH_GREEN, n, val)) begin
               hit = 1'b1;
               ch  = CH_GREEN;
            end else if (keyword_value(CH_BLUE, n, val)) begin
               hit = 1'b1;
               ch  = CH_BLUE;
            end
            if (!hit) begin
               r.outcome = OUT_NO_COMMAND;
            end else if (val > int'(level_limit)) begin
               r.outcome = OUT_INVALID;
               r.channel = ch;
            end else begin
               r.outcome = OUT_LEVEL_SET;
               r.channel = ch;
               r.level   = val[7:0];
               r.duty    = 16'(val * val);
            end
            line_fill = 0;
            replies_due.push_back(r);
         end else if (b == CHAR_BACKSPACE) begin
            // backspace on an empty line is swallowed
            if (line_fill != 0) begin
               line_fill--;
               r.outcome   = OUT_ECHO_BACK;
               r.echo_char = CHAR_BACKSPACE;
               replies_due.push_back(r);
            end
         end else if (line_fill < LINE_DEPTH) begin
            line_bytes[line_fill] = b;
            line_fill++;
            r.outcome   = OUT_ECHO_CHAR;
            r.echo_char = b;
            replies_due.push_back(r);
         end
      endfunction

      function void compare_field(string what, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
         end
      endfunction

      // compare a reply word with the oldest one due
      function void check_reply(console_reply_type got);
         console_reply_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: reply with none due, expected nothing, actual outcome %0d",
                     $time, got.outcome);
            errors++;
         end else begin
            want = replies_due.pop_front();
            compare_field("outcome", 16'(want.outcome), 16'(got.outcome));
            compare_field("echo_char", 16'(want.echo_char), 16'(got.echo_char));
            compare_field("channel", 16'(want.channel), 16'(got.channel));
            compare_field("level", 16'(want.level), 16'(got.level));
            compare_field("duty", want.duty, got.duty);
         end
      endfunction
   endclass

   console_scoreboard board = new();

   rgb_command_line_interpreter #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_outcome  (rsp_outcome),
      .rsp_echo_char(rsp_echo_char),
      .rsp_channel  (rsp_channel),
      .rsp_level    (rsp_level),
      .rsp_duty     (rsp_duty),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // mostly short pauses, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_mode && $urandom_range(0, 99) < 25) begin
         stall_left = pick_pause() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // reply words are sampled mid-cycle, taken at the next edge
   always @(negedge clock) begin
      console_reply_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.outcome   = outcome_type'(rsp_outcome);
         got.echo_char = rsp_echo_char;
         got.channel   = channel_type'(rsp_channel);
         got.level     = rsp_level;
         got.duty      = rsp_duty;
         board.check_reply(got);
      end
   end

   // present one byte and hold it until taken; valid stays high afterwards
   task automatic send_byte(logic [7:0] b);
      bit taken;
      if (idle_mode && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (pick_pause()) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         taken = req_ready;
         if (taken) board.predict_reply(b);
         @(posedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // drop valid, wait for every reply, then let words that get no reply drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.replies_due.size() != 0) @(posedge clock);
      repeat (LINE_DEPTH + 10) @(posedge clock);
   endtask

   task automatic write_limit(logic [7:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.level_limit = v;
   endtask

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 4))
         0:       return 8'd9;
         1:       return 8'd10;
         2:       return 8'd11;
         3:       return 8'd12;
         default: return 8'd32;
      endcase
   endfunction

   // decimal level, clustered round the current limit
   function automatic string level_digits();
      int    v;
      string s;
      case ($urandom_range(0, 5))
         0:       v = int'(board.level_limit);
         1:       v = int'(board.level_limit) + 1;
         2:       v = 0;
         3:       v = $urandom_range(0, 255);
         4:       v = $urandom_range(0, 1200);
         default: v = $urandom_range(0, 999999);
      endcase
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) s = {"00", s};
      return s;
   endfunction

   // one line of random shape, mostly well-formed commands
   task automatic send_random_line();
      int          kind;
      string       kw;
      channel_type ch;
      kind = $urandom_range(0, 99);
      ch   = channel_type'($urandom_range(0, 2));
      kw   = channel_word(ch);
      if (kind < 60) begin
         send_text(kw);
         repeat ($urandom_range(0, 3)) send_byte(blank_byte());
         if ($urandom_range(0, 3) == 0) send_text("+");
         send_text(level_digits());
         // typo corrected with backspace
         if ($urandom_range(0, 4) == 0) begin
            send_byte(8'($urandom_range(32, 126)));
            send_byte(CHAR_BACKSPACE);
         end
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
         // near misses
         case ($urandom_range(0, 4))
            0: send_text({kw.substr(0, kw.len() - 2), " ", level_digits()});
            1: send_text({kw, " -", level_digits()});
            2: begin
               send_text(kw);
               repeat ($urandom_range(0, 3)) send_byte(blank_byte());
            end
            3: begin
               send_byte(blank_byte());
               send_text({kw, " ", level_digits()});
            end
            default: send_text({kw.toupper(), " ", level_digits()});
         endcase
      end else if (kind < 90) begin
         repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
         // editing, backspaces often on an empty line
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1) == 0) send_byte(CHAR_BACKSPACE);
            else send_byte(8'($urandom_range(32, 126)));
         end
      end else begin
         // overlong line, tail dropped once the buffer is full
         if ($urandom_range(0, 1) == 0) send_text({kw, " ", level_digits()});
         repeat ($urandom_range(118, 134)) send_byte(8'($urandom_range(33, 126)));
         repeat ($urandom_range(0, 2)) send_byte(CHAR_BACKSPACE);
      end
      send_byte(CHAR_ENTER);
   endtask

   initial begin
      logic [7:0] stage_limit [6];
      int         stage;
      int         start;
      stage_limit = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd128,
                      8'($urandom_range(0, 255))};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_limit(8'd255);

      // directed lines
      send_byte(CHAR_BACKSPACE);
      send_byte(CHAR_ENTER);
      send_text("red 0");
      send_byte(CHAR_ENTER);
      send_text("green+255");
      send_byte(CHAR_ENTER);
      send_text("blue");
      send_byte(8'd9);
      send_byte(8'd11);
      send_byte(8'd32);
      send_text("7");
      send_byte(CHAR_ENTER);
      send_text("red 256");
      send_byte(CHAR_ENTER);
      send_text("blue 99999");
      send_byte(CHAR_ENTER);
      send_text("red -5");
      send_byte(CHAR_ENTER);
      send_text("green");
      send_byte(CHAR_ENTER);
      send_text("redgreen 5");
      send_byte(CHAR_ENTER);
      send_text("rex");
      send_byte(CHAR_BACKSPACE);
      send_text("d 17xyz");
      send_byte(CHAR_ENTER);
      // a zero byte ends the parsed text
      send_text("red 5");
      send_byte(8'd0);
      send_text("9");
      send_byte(CHAR_ENTER);
      send_byte(8'd0);
      send_text("red 5");
      send_byte(CHAR_ENTER);
      send_byte(8'hff);
      send_byte(8'h80);
      send_byte(CHAR_ENTER);
      // full line: the last bytes are dropped
      send_text("blue 9");
      repeat (125) send_byte("x");
      send_byte(CHAR_BACKSPACE);
      send_byte(CHAR_ENTER);

      // random lines under several limits, one stage without idling
      for (stage = 0; stage < 6; stage++) begin
         write_limit(stage_limit[stage]);
         idle_mode = (stage != 2);
         start = bytes_sent;
         while (bytes_sent - start < 195) send_random_line();
      end

      wait_idle();
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: rgb_command_line_interpreter.f
design/rgbcli_pkg.sv
design/rgbcli_front.sv
design/rgbcli_back.sv
design/rgb_command_line_interpreter.sv
verif/tb_rgb_command_line_interpreter.sv
